/* sv/ppms_pkg.sv */
package ppms_pkg;

    localparam int MAX_IMAGES = 16;
    localparam int IDX_W = $clog2(MAX_IMAGES);
    localparam int CNT_W = $clog2(MAX_IMAGES + 1);
    localparam int NUM_IMAGES_W = 5;
    localparam int PIX_W = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_NUM_IMAGES = 1'b0;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_median;
        logic [PIX_W-1:0] green_median;
        logic [PIX_W-1:0] blue_median;
    } median_t;

    typedef struct packed {
        logic             insert;
        logic [IDX_W-1:0] count;
        logic [IDX_W-1:0] rank;
    } lane_ctrl_t;

endpackage

/* sv/per_pixel_median_stack.sv */
// Temporal median over a stack of aligned RGB frames, one pixel position at a
// time. The pixel channel carries one frame's pixel per transaction; after
// num_images transactions the median channel delivers one RGB pixel whose
// channels are the upper medians of the collected values. Both channels use
// valid/stall handshakes; the APB port holds num_images at address 0, where
// 0 acts as 1 and values above 16 act as 16.
// Each color channel has its own sorted cell chain, so every accepted pixel
// is inserted into all three chains in parallel. When the last pixel of a set
// is accepted, the pixel channel stalls while the merge is pending, until the
// merge stage reads the middle cell of each chain into the output register;
// the result is registered there and turns valid when that register loads.
// If the receiver stalls, the result waits in the output register, and the
// next set is still collected; once that next set is complete, the pixel
// channel stalls until the waiting result is taken.
// Reset empties the chains, clears the output valid flag and sets num_images
// to 1. Sample storage itself is not cleared.
module per_pixel_median_stack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppms_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  ppms_pkg::pixel_t                pixel,
    output logic                            median_valid,
    input  logic                            median_stall,
    output ppms_pkg::median_t               median
);

    logic [ppms_pkg::NUM_IMAGES_W-1:0] num_images_reg;
    logic [ppms_pkg::IDX_W-1:0]        count_reg;
    logic [ppms_pkg::IDX_W-1:0]        count_next;
    logic [ppms_pkg::IDX_W-1:0]        rank_reg;
    logic [ppms_pkg::IDX_W-1:0]        rank_next;
    logic                              pend_reg;
    logic                              pend_next;
    logic [ppms_pkg::CNT_W-1:0]        n_eff;
    logic [ppms_pkg::CNT_W-1:0]        filled;
    logic                              accept;
    logic                              last;
    logic                              taken;
    ppms_pkg::lane_ctrl_t              ctrl;
    logic [ppms_pkg::PIX_W-1:0]        red_lane;
    logic [ppms_pkg::PIX_W-1:0]        green_lane;
    logic [ppms_pkg::PIX_W-1:0]        blue_lane;

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[ppms_pkg::APB_ADDR_W-1] == ppms_pkg::REG_NUM_IMAGES)
        begin
            prdata = ppms_pkg::APB_DATA_W'(num_images_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_images_reg <= ppms_pkg::NUM_IMAGES_W'(1);
        end
        else if (psel && penable && pwrite && pready
                 && paddr[ppms_pkg::APB_ADDR_W-1] == ppms_pkg::REG_NUM_IMAGES)
        begin
            num_images_reg <= pwdata[ppms_pkg::NUM_IMAGES_W-1:0];
        end
    end

    always_comb
    begin
        if (num_images_reg == '0)
        begin
            n_eff = ppms_pkg::CNT_W'(1);
        end
        else if (int'(num_images_reg) > ppms_pkg::MAX_IMAGES)
        begin
            n_eff = ppms_pkg::CNT_W'(ppms_pkg::MAX_IMAGES);
        end
        else
        begin
            n_eff = ppms_pkg::CNT_W'(num_images_reg);
        end
    end

    // A waiting merge would read the chains, so no new pixel goes in meanwhile.
    assign pixel_stall = pend_reg;
    assign accept      = pixel_valid && !pend_reg;
    assign filled      = ppms_pkg::CNT_W'(count_reg) + ppms_pkg::CNT_W'(1);
    assign last        = filled >= n_eff;

    always_comb
    begin
        count_next = count_reg;
        rank_next  = rank_reg;
        pend_next  = pend_reg;
        if (taken)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            if (last)
            begin
                count_next = '0;
                rank_next  = ppms_pkg::IDX_W'(filled >> 1);
                pend_next  = 1'b1;
            end
            else
            begin
                count_next = filled[ppms_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rank_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rank_reg  <= rank_next;
            pend_reg  <= pend_next;
        end
    end

    assign ctrl.insert = accept;
    assign ctrl.count  = count_reg;
    assign ctrl.rank   = rank_reg;

    ppms_sort_lane u_red_lane (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (pixel.red_in),
        .median (red_lane)
    );

    ppms_sort_lane u_green_lane (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (pixel.green_in),
        .median (green_lane)
    );

    ppms_sort_lane u_blue_lane (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (pixel.blue_in),
        .median (blue_lane)
    );

    ppms_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (pend_reg),
        .red_lane     (red_lane),
        .green_lane   (green_lane),
        .blue_lane    (blue_lane),
        .taken        (taken),
        .median_valid (median_valid),
        .median_stall (median_stall),
        .median       (median)
    );

    // A new result only ever comes from a pending merge.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(median_valid) |-> $past(pend_reg))
        else $error("median_valid rose without a pending merge");

    // Completing a set always empties the chains.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> count_reg == '0)
        else $error("chains not emptied while a merge is pending");

    // The middle index never goes past the first cell of the upper half of a full chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> int'(rank_reg) <= ppms_pkg::MAX_IMAGES / 2)
        else $error("median rank out of range");

    // Accepting the last pixel of a set schedules a merge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> pend_reg)
        else $error("last pixel of a set did not start a merge");

endmodule

/* sv/ppms_sort_lane.sv */
module ppms_sort_lane (
    input  logic                      clk,
    input  ppms_pkg::lane_ctrl_t      ctrl,
    input  logic [ppms_pkg::PIX_W-1:0] sample,
    output logic [ppms_pkg::PIX_W-1:0] median
);

    logic [ppms_pkg::PIX_W-1:0] cells_reg [ppms_pkg::MAX_IMAGES];
    logic [ppms_pkg::PIX_W-1:0] cells_next [ppms_pkg::MAX_IMAGES];
    logic [ppms_pkg::MAX_IMAGES-1:0] gt;

    // The chain is kept sorted ascending over its first count cells. Every cell
    // larger than the new sample moves up one place, and the sample drops into
    // the gap left below them.
    always_comb
    begin
        for (int i = 0; i < ppms_pkg::MAX_IMAGES; i++)
        begin
            gt[i] = (ppms_pkg::IDX_W'(i) < ctrl.count) && (cells_reg[i] > sample);
        end
        for (int i = 0; i < ppms_pkg::MAX_IMAGES; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (ctrl.insert && (gt[i] || (ppms_pkg::IDX_W'(i) == ctrl.count)))
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
                else
                begin
                    cells_next[i] = sample;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ppms_pkg::MAX_IMAGES; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    assign median = cells_reg[ctrl.rank];

endmodule

/* sv/ppms_merge.sv */
module ppms_merge (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [ppms_pkg::PIX_W-1:0] red_lane,
    input  logic [ppms_pkg::PIX_W-1:0] green_lane,
    input  logic [ppms_pkg::PIX_W-1:0] blue_lane,
    output logic                       taken,
    output logic                       median_valid,
    input  logic                       median_stall,
    output ppms_pkg::median_t          median
);

    logic              valid_reg;
    logic              valid_next;
    ppms_pkg::median_t data_reg;

    // The output register frees up either when it is empty or when its
    // transaction completes in this cycle.
    assign taken = load && (!valid_reg || !median_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (taken)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !median_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            data_reg.red_median   <= red_lane;
            data_reg.green_median <= green_lane;
            data_reg.blue_median  <= blue_lane;
        end
    end

    assign median_valid = valid_reg;
    assign median       = data_reg;

endmodule
